FILE: sv/bpt_pkg.sv
// shared types, constants and helper functions of the perceptron trainer
`timescale 1ns / 1ps

package bpt_pkg;

    localparam int NUM_INPUTS   = 15;
    localparam int WEIGHT_BITS  = 16;
    localparam int PIXEL_BITS   = 15;
    localparam int SUM_BITS     = 20;
    localparam int THRESH_BITS  = 20;
    localparam int ADDR_BITS    = 3;
    localparam int DATA_BITS    = 32;

    localparam int TREE_LEVELS  = $clog2(NUM_INPUTS);
    localparam int TREE_N       = 1 << TREE_LEVELS;
    localparam int RAW_SUM_BITS = WEIGHT_BITS + TREE_LEVELS;
    localparam int ACC_BITS     = (RAW_SUM_BITS > SUM_BITS) ? RAW_SUM_BITS : SUM_BITS + 1;

    typedef logic signed [WEIGHT_BITS-1:0] weight_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic signed [THRESH_BITS-1:0] thresh_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic [PIXEL_BITS-1:0]         pixels_t;
    typedef logic [NUM_INPUTS-1:0]         lane_vec_t;

    localparam weight_t WEIGHT_MAX   = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam weight_t WEIGHT_MIN   = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
    localparam acc_t    SUM_HI       = {{(ACC_BITS-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
    localparam acc_t    SUM_LO       = ~SUM_HI;
    localparam thresh_t THRESH_RESET = THRESH_BITS'(35);
    localparam pixels_t TARGET_RESET = PIXEL_BITS'(18925);

    typedef enum logic {
        OP_TRAIN    = 1'b0,
        OP_CLASSIFY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_INC  = 2'd1,
        ACT_DEC  = 2'd2
    } action_t;

    typedef enum logic {
        REG_THRESHOLD = 1'b0,
        REG_TARGET    = 1'b1
    } reg_idx_t;

    // fired sits in bit 0, then the sum, then the action
    typedef struct packed {
        action_t update_action;
        sum_t    weighted_sum;
        logic    fired;
    } result_t;

    typedef struct packed {
        logic inc;
        logic dec;
    } lane_upd_t;

    // starting weight of one lane, clamped to the weight range
    function automatic weight_t init_weight(int idx);
        longint v;
        longint hi;
        longint lo;
        case (idx)
            0:       v = 62;
            1:       v = -115;
            2:       v = 1;
            3:       v = 62;
            4:       v = -58;
            5:       v = 60;
            6:       v = 0;
            7:       v = 64;
            8:       v = 1;
            9:       v = -57;
            10:      v = 3;
            11:      v = 7;
            12:      v = -118;
            13:      v = -115;
            14:      v = 7;
            default: v = 0;
        endcase
        hi = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return weight_t'(v);
    endfunction

    // map an image onto the lanes, missing bits read as zero
    function automatic lane_vec_t to_lanes(pixels_t v);
        logic [NUM_INPUTS+PIXEL_BITS-1:0] tmp;
        tmp = '0;
        tmp[PIXEL_BITS-1:0] = v;
        return tmp[NUM_INPUTS-1:0];
    endfunction

endpackage

FILE: sv/binary_perceptron_trainer_unit.sv
// top level of the online perceptron trainer: lanes, merge, result buffer, registers
//
//  channel   ports          payload (lsb first)
//  input     s_t*           tdata: pixels[14:0]; tuser: operation
//  result    m_t*           tdata: fired, weighted_sum[19:0], update_action[1:0]
//  config    p*             0x0 fire_threshold, 0x4 target_pattern
//
// one item per clock while s_tready is high, one result per item; the weight loop
// (lane registers -> adder tree -> compare -> update) closes on each accepted item.
// reset reloads the starting weights and register defaults. a two-entry result buffer
// keeps the input open while m_tready is low, until its skid entry fills.
`timescale 1ns / 1ps

module binary_perceptron_trainer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // pixels[14:0], zero pad
    input  logic                           s_tuser,   // operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // fired, weighted_sum, update_action, pad
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpt_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [bpt_pkg::DATA_BITS-1:0]  pwdata,
    output logic [bpt_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);
    import bpt_pkg::*;

    thresh_t   threshold_reg;
    pixels_t   target_reg;
    reg_idx_t  reg_idx;
    logic      cfg_wr;

    logic      s_acc;
    op_t       op;
    lane_vec_t px_lanes;
    lane_vec_t tgt_lanes;
    weight_t   contrib [NUM_INPUTS];
    result_t   res;
    lane_upd_t upd;

    logic      out_valid_reg, out_valid_next;
    result_t   out_data_reg, out_data_next;
    logic      skid_valid_reg, skid_valid_next;
    result_t   skid_data_reg, skid_data_next;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = DATA_BITS'(threshold_reg);
            REG_TARGET:    prdata = DATA_BITS'(target_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESH_RESET;
            target_reg    <= TARGET_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_THRESHOLD: threshold_reg <= pwdata[THRESH_BITS-1:0];
                REG_TARGET:    target_reg    <= pwdata[PIXEL_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // lanes and merge
    assign s_tready  = !skid_valid_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign op        = op_t'(s_tuser);
    assign px_lanes  = to_lanes(s_tdata[PIXEL_BITS-1:0]);
    assign tgt_lanes = to_lanes(target_reg);

    assign upd.inc = s_acc && (res.update_action == ACT_INC);
    assign upd.dec = s_acc && (res.update_action == ACT_DEC);

    genvar gi;
    generate
        for (gi = 0; gi < NUM_INPUTS; gi++) begin : g_lane
            bpt_lane u_lane (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .init_value (init_weight(gi)),
                .pixel      (px_lanes[gi]),
                .upd        (upd),
                .contrib    (contrib[gi])
            );
        end
    endgenerate

    bpt_merge u_merge (
        .contrib   (contrib),
        .threshold (threshold_reg),
        .px_lanes  (px_lanes),
        .tgt_lanes (tgt_lanes),
        .op        (op),
        .result    (res)
    );

    // result buffer: output register plus skid entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (s_acc) begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (s_acc) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

    // checks
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> m_tvalid)
        else $error("accepted item produced no result");

    a_classify_no_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (op == OP_CLASSIFY)) |-> (res.update_action == ACT_NONE))
        else $error("classify item updated weights");

    a_action_matches_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (res.update_action == ACT_INC)) |-> !res.fired)
        else $error("weights increased after a fire");

    a_action_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg.update_action == ACT_NONE ||
                           out_data_reg.update_action == ACT_INC ||
                           out_data_reg.update_action == ACT_DEC))
        else $error("bad update action in result");

endmodule

FILE: sv/bpt_lane.sv
// one perceptron input lane: weight register, masked contribution, update
`timescale 1ns / 1ps

module bpt_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpt_pkg::weight_t    init_value,
    input  logic                pixel,
    input  bpt_pkg::lane_upd_t  upd,
    output bpt_pkg::weight_t    contrib
);
    import bpt_pkg::*;

    weight_t weight_reg;
    weight_t weight_next;

    assign contrib = pixel ? weight_reg : '0;

    always_comb begin
        weight_next = weight_reg;
        if (pixel) begin
            if (upd.inc && (weight_reg != WEIGHT_MAX)) begin
                weight_next = weight_reg + weight_t'(1);
            end else if (upd.dec && (weight_reg != WEIGHT_MIN)) begin
                weight_next = weight_reg - weight_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= init_value;
        end else begin
            weight_reg <= weight_next;
        end
    end

endmodule

FILE: sv/bpt_merge.sv
// adder tree over the lane contributions, threshold compare and learning decision
`timescale 1ns / 1ps

module bpt_merge (
    input  bpt_pkg::weight_t   contrib [bpt_pkg::NUM_INPUTS],
    input  bpt_pkg::thresh_t   threshold,
    input  bpt_pkg::lane_vec_t px_lanes,
    input  bpt_pkg::lane_vec_t tgt_lanes,
    input  bpt_pkg::op_t       op,
    output bpt_pkg::result_t   result
);
    import bpt_pkg::*;

    acc_t  node [TREE_LEVELS+1][TREE_N];
    sum_t  sum_sat;
    logic  fired;
    logic  target;

    genvar gi, lv;
    generate
        for (gi = 0; gi < TREE_N; gi++) begin : g_leaf
            if (gi < NUM_INPUTS) begin : g_used
                assign node[0][gi] = acc_t'(contrib[gi]);
            end else begin : g_pad
                assign node[0][gi] = '0;
            end
        end
        for (lv = 0; lv < TREE_LEVELS; lv++) begin : g_level
            for (gi = 0; gi < (TREE_N >> (lv + 1)); gi++) begin : g_add
                assign node[lv+1][gi] = node[lv][2*gi] + node[lv][2*gi+1];
            end
        end
    endgenerate

    always_comb begin
        if (node[TREE_LEVELS][0] > SUM_HI) begin
            sum_sat = SUM_HI[SUM_BITS-1:0];
        end else if (node[TREE_LEVELS][0] < SUM_LO) begin
            sum_sat = SUM_LO[SUM_BITS-1:0];
        end else begin
            sum_sat = node[TREE_LEVELS][0][SUM_BITS-1:0];
        end
    end

    assign fired  = sum_sat > threshold;
    assign target = px_lanes == tgt_lanes;

    always_comb begin
        result.fired         = fired;
        result.weighted_sum  = sum_sat;
        result.update_action = ACT_NONE;
        if (op == OP_TRAIN) begin
            if (target && !fired) begin
                result.update_action = ACT_INC;
            end else if (!target && fired) begin
                result.update_action = ACT_DEC;
            end
        end
    end

endmodule
